>>> design/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define HCSD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Condition in one cycle implies a condition in the next.
`define HCSD_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/hcsd_pkg.sv
// Types, constants and codes of the host command stream deframer.
package hcsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int LEN_W      = 25;
    localparam int WIN_DEPTH  = 17;
    localparam int COUNT_W    = $clog2(WIN_DEPTH + 1);
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TUSER_W  = 3;
    localparam int M_FIELDS_W = BYTE_W + 2 * WORD_W + LEN_W + BYTE_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [COUNT_W-1:0] CNT_DETECT     = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] CNT_PROBE      = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] HDR_DIRECT     = COUNT_W'(12);
    localparam logic [COUNT_W-1:0] HDR_KEEPALIVE  = COUNT_W'(13);
    localparam logic [COUNT_W-1:0] HDR_REMOTE     = COUNT_W'(WIN_DEPTH);

    localparam logic [WORD_W-1:0] MAX_PAYLOAD    = WORD_W'(16 * 1024 * 1024);
    localparam logic [WORD_W-1:0] KEEPALIVE_WORD = 32'hcafe_beef;
    localparam logic [WORD_W-1:0] REMOTE_TYPE    = 32'h0000_0001;
    localparam logic [WORD_W-1:0] STATUS_LEN     = 32'd4;

    localparam logic [BYTE_W-1:0] CH_C    = 8'h43;  // 'C'
    localparam logic [BYTE_W-1:0] CH_M    = 8'h4d;  // 'M'
    localparam logic [BYTE_W-1:0] CH_D    = 8'h44;  // 'D'
    localparam logic [BYTE_W-1:0] CH_U    = 8'h55;  // 'U'
    localparam logic [BYTE_W-1:0] CH_S_LO = 8'h73;  // 's'
    localparam logic [BYTE_W-1:0] CH_S_HI = 8'h53;  // 'S'

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        MODE_UNDET  = 3'b001,
        MODE_DIRECT = 3'b010,
        MODE_REMOTE = 3'b100
    } mode_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic              framing;
        logic [BYTE_W-1:0] command_code;
        logic [WORD_W-1:0] first_arg;
        logic [WORD_W-1:0] second_arg;
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } result_t;

endpackage

>>> design/hcsd_in_stage.sv
// Input register stage of the deframer.
module hcsd_in_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hcsd_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] byte_in
    input  logic [hcsd_pkg::S_TUSER_W-1:0]     s_tuser,   // [0] operation
    input  logic                               advance,
    output logic                               item_valid,
    output hcsd_pkg::item_t                    item
);

    logic            valid_reg;
    logic            valid_next;
    hcsd_pkg::item_t item_reg;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op   <= s_tuser[0];
            item_reg.data <= s_tdata[hcsd_pkg::BYTE_W-1:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> design/hcsd_parser.sv
// Framing detection, header collection and payload counting.
`include "assert_macros.svh"

module hcsd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  hcsd_pkg::item_t     item,
    input  logic                out_space,
    output logic                advance,
    output logic                emit,
    output hcsd_pkg::result_t   result
);

    hcsd_pkg::mode_t                     mode_reg;
    hcsd_pkg::mode_t                     mode_next;
    logic [hcsd_pkg::COUNT_W-1:0]        count_reg;
    logic [hcsd_pkg::COUNT_W-1:0]        count_next;
    logic [hcsd_pkg::COUNT_W-1:0]        count_inc;
    logic [hcsd_pkg::LEN_W-1:0]          left_reg;
    logic [hcsd_pkg::LEN_W-1:0]          left_next;
    logic [hcsd_pkg::BYTE_W-1:0]         window_reg  [hcsd_pkg::WIN_DEPTH];
    logic [hcsd_pkg::BYTE_W-1:0]         window_next [hcsd_pkg::WIN_DEPTH];
    logic                                shift_en;

    logic                                det_direct_ok;
    logic                                det_remote_ok;
    logic                                dir_magic_ok;
    logic [hcsd_pkg::BYTE_W-1:0]         dir_cmd;
    logic [hcsd_pkg::WORD_W-1:0]         dir_a0;
    logic [hcsd_pkg::WORD_W-1:0]         dir_a1;
    logic [hcsd_pkg::WORD_W-1:0]         dir_len;
    logic [hcsd_pkg::WORD_W-1:0]         rem_type;
    logic [hcsd_pkg::BYTE_W-1:0]         rem_cmd;
    logic [hcsd_pkg::WORD_W-1:0]         rem_a0;
    logic [hcsd_pkg::WORD_W-1:0]         rem_a1;
    logic [hcsd_pkg::WORD_W-1:0]         rem_len;

    logic                                hdr_hit;
    logic                                err_hit;
    logic                                hdr_framing;
    logic [hcsd_pkg::BYTE_W-1:0]         hdr_cmd;
    logic [hcsd_pkg::WORD_W-1:0]         hdr_a0;
    logic [hcsd_pkg::WORD_W-1:0]         hdr_a1;
    logic [hcsd_pkg::WORD_W-1:0]         hdr_len;

    // Newest byte enters at the top; a header always ends at the top entry.
    always_comb begin
        for (int i = 0; i < hcsd_pkg::WIN_DEPTH - 1; i++) begin
            window_next[i] = window_reg[i+1];
        end
        window_next[hcsd_pkg::WIN_DEPTH-1] = item.data;
    end

    assign det_direct_ok = (window_next[14] == hcsd_pkg::CH_C) &&
                           (window_next[15] == hcsd_pkg::CH_M) &&
                           (window_next[16] == hcsd_pkg::CH_D);
    assign det_remote_ok = ({window_next[13], window_next[14],
                             window_next[15], window_next[16]} == hcsd_pkg::REMOTE_TYPE);

    // Direct header sits in the top twelve entries.
    assign dir_magic_ok = (window_next[5] == hcsd_pkg::CH_C) &&
                          (window_next[6] == hcsd_pkg::CH_M) &&
                          (window_next[7] == hcsd_pkg::CH_D);
    assign dir_cmd = window_next[8];
    assign dir_a0  = {window_next[9],  window_next[10], window_next[11], window_next[12]};
    assign dir_a1  = {window_next[13], window_next[14], window_next[15], window_next[16]};

    assign rem_type = {window_next[0],  window_next[1],  window_next[2],  window_next[3]};
    assign rem_cmd  = window_next[4];
    assign rem_a0   = {window_next[5],  window_next[6],  window_next[7],  window_next[8]};
    assign rem_a1   = {window_next[9],  window_next[10], window_next[11], window_next[12]};
    assign rem_len  = {window_next[13], window_next[14], window_next[15], window_next[16]};

    always_comb begin
        unique case (dir_cmd) inside
            hcsd_pkg::CH_M, hcsd_pkg::CH_U:       dir_len = dir_a1;
            hcsd_pkg::CH_S_LO, hcsd_pkg::CH_S_HI: dir_len = hcsd_pkg::STATUS_LEN;
            default:                              dir_len = '0;
        endcase
    end

    assign count_inc = (count_reg >= hcsd_pkg::HDR_REMOTE) ?
                       hcsd_pkg::COUNT_W'(1) : count_reg + hcsd_pkg::COUNT_W'(1);

    always_comb begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        shift_en    = 1'b0;
        emit        = 1'b0;
        result      = '0;
        hdr_hit     = 1'b0;
        err_hit     = 1'b0;
        hdr_framing = 1'b0;
        hdr_cmd     = '0;
        hdr_a0      = '0;
        hdr_a1      = '0;
        hdr_len     = '0;

        if (item.op == hcsd_pkg::OP_CLEAR) begin
            mode_next  = hcsd_pkg::MODE_UNDET;
            count_next = '0;
            left_next  = '0;
        end else if ((mode_reg == hcsd_pkg::MODE_DIRECT || mode_reg == hcsd_pkg::MODE_REMOTE) &&
                     left_reg != '0) begin
            emit                = 1'b1;
            result.kind         = hcsd_pkg::KIND_PAYLOAD;
            result.framing      = (mode_reg == hcsd_pkg::MODE_REMOTE);
            result.payload_byte = item.data;
            result.last         = (left_reg == hcsd_pkg::LEN_W'(1));
            left_next           = left_reg - hcsd_pkg::LEN_W'(1);
        end else begin
            shift_en   = 1'b1;
            count_next = count_inc;
            unique case (mode_reg)
                hcsd_pkg::MODE_DIRECT: begin
                    if (count_inc == hcsd_pkg::HDR_DIRECT) begin
                        if (!dir_magic_ok || dir_len > hcsd_pkg::MAX_PAYLOAD) begin
                            err_hit = 1'b1;
                        end else begin
                            hdr_hit     = 1'b1;
                            hdr_framing = 1'b0;
                            hdr_cmd     = dir_cmd;
                            hdr_a0      = dir_a0;
                            hdr_a1      = dir_a1;
                            hdr_len     = dir_len;
                        end
                    end
                end
                hcsd_pkg::MODE_REMOTE: begin
                    if (count_inc == hcsd_pkg::HDR_REMOTE) begin
                        if (rem_type == hcsd_pkg::KEEPALIVE_WORD) begin
                            // drop the keepalive word, keep the thirteen bytes after it
                            count_next = hcsd_pkg::HDR_KEEPALIVE;
                        end else if (rem_type != hcsd_pkg::REMOTE_TYPE ||
                                     rem_len > hcsd_pkg::MAX_PAYLOAD) begin
                            err_hit = 1'b1;
                        end else begin
                            hdr_hit     = 1'b1;
                            hdr_framing = 1'b1;
                            hdr_cmd     = rem_cmd;
                            hdr_a0      = rem_a0;
                            hdr_a1      = rem_a1;
                            hdr_len     = rem_len;
                        end
                    end
                end
                default: begin
                    mode_next = hcsd_pkg::MODE_UNDET;
                    if (count_inc == hcsd_pkg::CNT_DETECT && det_direct_ok) begin
                        mode_next = hcsd_pkg::MODE_DIRECT;
                    end else if (count_inc >= hcsd_pkg::CNT_PROBE) begin
                        if (det_remote_ok) begin
                            mode_next = hcsd_pkg::MODE_REMOTE;
                        end else begin
                            err_hit = 1'b1;
                        end
                    end
                end
            endcase

            if (err_hit) begin
                emit        = 1'b1;
                result.kind = hcsd_pkg::KIND_ERROR;
                mode_next   = hcsd_pkg::MODE_UNDET;
                count_next  = '0;
                left_next   = '0;
            end else if (hdr_hit) begin
                emit                  = 1'b1;
                result.kind           = hcsd_pkg::KIND_HEADER;
                result.framing        = hdr_framing;
                result.command_code   = hdr_cmd;
                result.first_arg      = hdr_a0;
                result.second_arg     = hdr_a1;
                result.payload_length = hdr_len[hcsd_pkg::LEN_W-1:0];
                result.last           = (hdr_len == '0);
                count_next            = '0;
                left_next             = hdr_len[hcsd_pkg::LEN_W-1:0];
            end
        end
    end

    // Hold the item while its result cannot be taken; others always pass.
    assign advance = item_valid && (!emit || out_space);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= hcsd_pkg::MODE_UNDET;
            count_reg <= '0;
            left_reg  <= '0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && shift_en) begin
            window_reg <= window_next;
        end
    end

    `HCSD_ASSERT(a_payload_needs_mode, aclk, aresetn, (left_reg == '0) || (mode_reg == hcsd_pkg::MODE_DIRECT) || (mode_reg == hcsd_pkg::MODE_REMOTE), "payload pending without detected framing")
    `HCSD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= hcsd_pkg::HDR_REMOTE, "header count past remote header size")
    `HCSD_ASSERT(a_undet_count, aclk, aresetn, (mode_reg != hcsd_pkg::MODE_UNDET) || (count_reg < hcsd_pkg::CNT_PROBE), "undetected framing holds four or more bytes")
    `HCSD_ASSERT_NEXT(a_clear_takes, aclk, aresetn, advance && (item.op == hcsd_pkg::OP_CLEAR), (mode_reg == hcsd_pkg::MODE_UNDET) && (count_reg == '0) && (left_reg == '0), "connection change did not clear the parser")

endmodule

>>> design/hcsd_out_stage.sv
// Result register stage of the deframer.
`include "assert_macros.svh"

module hcsd_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  hcsd_pkg::result_t                  result,
    output logic                               space,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] command_code, [39:8] first_arg, [71:40] second_arg,
    // [96:72] payload_length, [104:97] payload_byte, [111:105] zero
    output logic [hcsd_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] kind, [2] framing
    output logic [hcsd_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                               m_tlast
);

    logic              valid_reg;
    logic              valid_next;
    hcsd_pkg::result_t result_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{hcsd_pkg::M_PAD_W{1'b0}},
                       result_reg.payload_byte,
                       result_reg.payload_length,
                       result_reg.second_arg,
                       result_reg.first_arg,
                       result_reg.command_code};
    assign m_tuser  = {result_reg.framing, result_reg.kind};
    assign m_tlast  = result_reg.last;

    `HCSD_ASSERT(a_no_overwrite, aclk, aresetn, !load || !valid_reg || m_tready, "result loaded over a pending transaction")

endmodule

>>> design/host_command_stream_deframer.sv
// Top level of the host command stream deframer.
//
//   Channel | Direction | Contents
//   s_*     | in        | tdata: byte_in; tuser: operation (1 = connection change)
//   m_*     | out       | tdata: header fields / payload byte; tuser: kind, framing; tlast
//
// One byte transaction is accepted per clock while the input register is free or its byte
// advances; a result is presented from the result register, after its byte has passed
// through the input register and the parser.
// Header collection is a 17-byte shift register; payload bytes count down a
// 25-bit length counter, so every byte takes a single pass through the parser.
// aresetn (synchronous, active low) clears framing, counters and both valid flags.
// With m_tready low, bytes that give no result keep flowing; a byte that gives a
// result waits in the input register until the result register frees.
module host_command_stream_deframer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hcsd_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] byte_in
    input  logic [hcsd_pkg::S_TUSER_W-1:0]     s_tuser,   // [0] operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] command_code, [39:8] first_arg, [71:40] second_arg,
    // [96:72] payload_length, [104:97] payload_byte, [111:105] zero
    output logic [hcsd_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] kind, [2] framing
    output logic [hcsd_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                               m_tlast
);

    logic              item_valid;
    hcsd_pkg::item_t   item;
    logic              advance;
    logic              emit;
    logic              out_space;
    hcsd_pkg::result_t result;

    hcsd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hcsd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (out_space),
        .advance    (advance),
        .emit       (emit),
        .result     (result)
    );

    hcsd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .result   (result),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
